>>> hw/rtl/mlfq_three_level_scheduler_defines.svh
// assertion macros for the scheduler, clock clk and synchronous reset rst
`ifndef MLFQ_THREE_LEVEL_SCHEDULER_DEFINES_SVH
`define MLFQ_THREE_LEVEL_SCHEDULER_DEFINES_SVH
`ifndef SYNTHESIS
`define MLFQ_ASSERT(label, cond) \
  label: assert property (@(posedge clk) disable iff (rst) (cond)) \
    else $error("mlfq assertion failed");
`define MLFQ_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("mlfq assertion failed");
`else
`define MLFQ_ASSERT(label, cond)
`define MLFQ_ASSERT_IMP(label, ante, cons)
`endif
`endif

>>> hw/rtl/mlfq_pkg.sv
package mlfq_pkg;

  localparam logic [1:0] OP_NEW   = 2'd0;
  localparam logic [1:0] OP_BURST = 2'd1;
  localparam logic [1:0] OP_EXIT  = 2'd2;
  localparam logic [1:0] OP_TICK  = 2'd3;

  localparam logic [2:0] KIND_NEW_OK = 3'd0;
  localparam logic [2:0] KIND_BURST  = 3'd1;
  localparam logic [2:0] KIND_EXIT   = 3'd2;
  localparam logic [2:0] KIND_RAN    = 3'd3;
  localparam logic [2:0] KIND_IDLE   = 3'd4;
  localparam logic [2:0] KIND_ERROR  = 3'd5;

  localparam logic [2:0] REG_Q1       = 3'd0;
  localparam logic [2:0] REG_Q2       = 3'd1;
  localparam logic [2:0] REG_Q3       = 3'd2;
  localparam logic [2:0] REG_INTERVAL = 3'd3;
  localparam logic [2:0] REG_CAP      = 3'd4;

  localparam logic [7:0]  RST_Q1       = 8'd2;
  localparam logic [7:0]  RST_Q2       = 8'd4;
  localparam logic [7:0]  RST_Q3       = 8'd8;
  localparam logic [15:0] RST_INTERVAL = 16'd25;
  localparam logic [7:0]  RST_CAP      = 8'd2;

  localparam logic [4:0] CMD_NONE        = 5'd0;
  localparam logic [4:0] CMD_LOAD        = 5'd1;
  localparam logic [4:0] CMD_ERROR       = 5'd2;
  localparam logic [4:0] CMD_NEW         = 5'd3;
  localparam logic [4:0] CMD_BURST       = 5'd4;
  localparam logic [4:0] CMD_EXIT_SEARCH = 5'd5;
  localparam logic [4:0] CMD_EXIT_REPORT = 5'd6;
  localparam logic [4:0] CMD_PHASE       = 5'd7;
  localparam logic [4:0] CMD_MOVE_L2     = 5'd8;
  localparam logic [4:0] CMD_SCHED_PUSH  = 5'd9;
  localparam logic [4:0] CMD_SCHED_SET   = 5'd10;
  localparam logic [4:0] CMD_WAIT_INIT   = 5'd11;
  localparam logic [4:0] CMD_WAIT_STEP   = 5'd12;
  localparam logic [4:0] CMD_RUN_SEL     = 5'd13;
  localparam logic [4:0] CMD_IDLE        = 5'd14;
  localparam logic [4:0] CMD_RUN         = 5'd15;
  localparam logic [4:0] CMD_SW_RD       = 5'd16;
  localparam logic [4:0] CMD_SW_WR       = 5'd17;
  localparam logic [4:0] CMD_SW_END      = 5'd18;
  localparam logic [4:0] CMD_EMIT        = 5'd19;

  typedef struct packed {
    logic [1:0]  operation;
    logic [3:0]  task_id;
    logic [15:0] burst_length;
  } item_t;

  typedef struct packed {
    logic [2:0]  kind;
    logic        boosted;
    logic [3:0]  result_task;
    logic [15:0] requested;
    logic [15:0] used;
    logic [1:0]  level;
    logic [15:0] wait_total;
    logic [16:0] turnaround;
  } result_t;

  typedef struct packed {
    logic [7:0]  q1;
    logic [7:0]  q2;
    logic [7:0]  q3;
    logic [15:0] interval;
    logic [7:0]  cap;
  } cfg_t;

  typedef struct packed {
    logic [4:0] op;
  } cmd_t;

  typedef struct packed {
    logic [1:0] operation;
    logic       id_ok;
    logic       busy;
    logic       len_zero;
    logic       run_is_id;
    logic       level_nz;
    logic       boost_due;
    logic       sched_take;
    logic       run_valid;
    logic       sw_done;
    logic       wait_last;
    logic       out_free;
  } status_t;

endpackage

>>> hw/rtl/mlfq_regs.sv
module mlfq_regs (
  input  logic               clk,
  input  logic               rst,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [4:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready,
  output mlfq_pkg::cfg_t     cfg
);

  logic [2:0] idx;

  assign idx    = paddr[4:2];
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.q1       <= mlfq_pkg::RST_Q1;
      cfg.q2       <= mlfq_pkg::RST_Q2;
      cfg.q3       <= mlfq_pkg::RST_Q3;
      cfg.interval <= mlfq_pkg::RST_INTERVAL;
      cfg.cap      <= mlfq_pkg::RST_CAP;
    end else if (psel && penable && pwrite) begin
      case (idx)
        mlfq_pkg::REG_Q1:       cfg.q1       <= pwdata[7:0];
        mlfq_pkg::REG_Q2:       cfg.q2       <= pwdata[7:0];
        mlfq_pkg::REG_Q3:       cfg.q3       <= pwdata[7:0];
        mlfq_pkg::REG_INTERVAL: cfg.interval <= pwdata[15:0];
        mlfq_pkg::REG_CAP:      cfg.cap      <= pwdata[7:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      mlfq_pkg::REG_Q1:       prdata = 32'(cfg.q1);
      mlfq_pkg::REG_Q2:       prdata = 32'(cfg.q2);
      mlfq_pkg::REG_Q3:       prdata = 32'(cfg.q3);
      mlfq_pkg::REG_INTERVAL: prdata = 32'(cfg.interval);
      mlfq_pkg::REG_CAP:      prdata = 32'(cfg.cap);
      default:                prdata = 32'd0;
    endcase
  end

endmodule

>>> hw/rtl/mlfq_ctrl.sv
module mlfq_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                item_valid,
  output logic                item_ready,
  input  mlfq_pkg::status_t   status,
  output mlfq_pkg::cmd_t      cmd
);

  localparam logic [3:0] S_IDLE      = 4'd0;
  localparam logic [3:0] S_DECODE    = 4'd1;
  localparam logic [3:0] S_SW_RD     = 4'd2;
  localparam logic [3:0] S_SW_WR     = 4'd3;
  localparam logic [3:0] S_EXIT_FIN  = 4'd4;
  localparam logic [3:0] S_BOOST2    = 4'd5;
  localparam logic [3:0] S_SCHED     = 4'd6;
  localparam logic [3:0] S_SCHED_FIN = 4'd7;
  localparam logic [3:0] S_WAIT_INIT = 4'd8;
  localparam logic [3:0] S_WAIT      = 4'd9;
  localparam logic [3:0] S_RUN_SEL   = 4'd10;
  localparam logic [3:0] S_RUN       = 4'd11;
  localparam logic [3:0] S_DONE      = 4'd12;

  logic [3:0] state, state_next;
  logic [3:0] ret, ret_next;

  assign item_ready = (state == S_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      ret   <= S_IDLE;
    end else begin
      state <= state_next;
      ret   <= ret_next;
    end
  end

  always_comb begin
    state_next = state;
    ret_next   = ret;
    cmd.op     = mlfq_pkg::CMD_NONE;
    case (state)
      S_IDLE: begin
        if (item_valid) begin
          cmd.op     = mlfq_pkg::CMD_LOAD;
          state_next = S_DECODE;
        end
      end
      S_DECODE: begin
        state_next = S_DONE;
        if (status.operation == mlfq_pkg::OP_TICK) begin
          cmd.op = mlfq_pkg::CMD_PHASE;
          if (status.boost_due) begin
            ret_next   = S_BOOST2;
            state_next = S_SW_RD;
          end else begin
            state_next = S_SCHED;
          end
        end else if (!status.id_ok) begin
          cmd.op = mlfq_pkg::CMD_ERROR;
        end else begin
          case (status.operation)
            mlfq_pkg::OP_NEW:
              cmd.op = status.busy ? mlfq_pkg::CMD_ERROR : mlfq_pkg::CMD_NEW;
            mlfq_pkg::OP_BURST:
              cmd.op = (status.busy || status.len_zero) ? mlfq_pkg::CMD_ERROR
                                                         : mlfq_pkg::CMD_BURST;
            default: begin
              if (status.run_is_id) begin
                cmd.op = mlfq_pkg::CMD_ERROR;
              end else if (status.level_nz) begin
                cmd.op     = mlfq_pkg::CMD_EXIT_SEARCH;
                ret_next   = S_EXIT_FIN;
                state_next = S_SW_RD;
              end else begin
                cmd.op = mlfq_pkg::CMD_EXIT_REPORT;
              end
            end
          endcase
        end
      end
      // queue sweep: read one entry, then act on it
      S_SW_RD: begin
        if (status.sw_done) begin
          cmd.op     = mlfq_pkg::CMD_SW_END;
          state_next = ret;
        end else begin
          cmd.op     = mlfq_pkg::CMD_SW_RD;
          state_next = S_SW_WR;
        end
      end
      S_SW_WR: begin
        cmd.op     = mlfq_pkg::CMD_SW_WR;
        state_next = S_SW_RD;
      end
      S_EXIT_FIN: begin
        cmd.op     = mlfq_pkg::CMD_EXIT_REPORT;
        state_next = S_DONE;
      end
      S_BOOST2: begin
        cmd.op     = mlfq_pkg::CMD_MOVE_L2;
        ret_next   = S_SCHED;
        state_next = S_SW_RD;
      end
      S_SCHED: begin
        if (status.sched_take) begin
          cmd.op     = mlfq_pkg::CMD_SCHED_PUSH;
          ret_next   = S_SCHED_FIN;
          state_next = S_SW_RD;
        end else begin
          state_next = S_WAIT_INIT;
        end
      end
      S_SCHED_FIN: begin
        cmd.op     = mlfq_pkg::CMD_SCHED_SET;
        state_next = S_WAIT_INIT;
      end
      S_WAIT_INIT: begin
        cmd.op     = mlfq_pkg::CMD_WAIT_INIT;
        state_next = S_WAIT;
      end
      S_WAIT: begin
        cmd.op = mlfq_pkg::CMD_WAIT_STEP;
        if (status.wait_last) state_next = S_RUN_SEL;
      end
      S_RUN_SEL: begin
        if (status.run_valid) begin
          cmd.op     = mlfq_pkg::CMD_RUN_SEL;
          state_next = S_RUN;
        end else begin
          cmd.op     = mlfq_pkg::CMD_IDLE;
          state_next = S_DONE;
        end
      end
      S_RUN: begin
        cmd.op     = mlfq_pkg::CMD_RUN;
        state_next = S_DONE;
      end
      S_DONE: begin
        if (status.out_free) begin
          cmd.op     = mlfq_pkg::CMD_EMIT;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

endmodule

>>> hw/rtl/mlfq_dp.sv
`include "mlfq_three_level_scheduler_defines.svh"

module mlfq_dp #(
  parameter int TASK_COUNT = 16,
  parameter int TIME_WIDTH = 16
) (
  input  logic                clk,
  input  logic                rst,
  input  mlfq_pkg::cmd_t      cmd,
  output mlfq_pkg::status_t   status,
  input  mlfq_pkg::cfg_t      cfg,
  input  mlfq_pkg::item_t     item,
  output mlfq_pkg::result_t   result,
  output logic                result_valid,
  input  logic                result_ready
);

  localparam int TW = $clog2(TASK_COUNT);
  localparam int CW = $clog2(TASK_COUNT + 1);
  localparam logic [TIME_WIDTH-1:0] TMAX = '1;

  mlfq_pkg::item_t   cur;
  mlfq_pkg::result_t res;
  mlfq_pkg::result_t res_load;
  logic [TW-1:0]         tidx;
  logic [1:0]            task_level [TASK_COUNT];
  logic [TIME_WIDTH-1:0] req        [TASK_COUNT];
  logic [TIME_WIDTH-1:0] rem        [TASK_COUNT];
  logic [TIME_WIDTH-1:0] exec_cnt   [TASK_COUNT];
  logic [TIME_WIDTH-1:0] wait_cnt   [TASK_COUNT];
  logic [TW-1:0]         qmem [0:2][0:TASK_COUNT-1];
  logic [TW-1:0]         rdata;
  logic [CW-1:0]         cnt [0:2];
  logic [1:0]            sw_q;
  logic [CW-1:0]         sw_p;
  logic                  sw_found;
  logic                  sw_move;
  logic [TW-1:0]         sw_head;
  logic [1:0]            sched_hl;
  logic [TW-1:0]         run_id;
  logic                  run_valid;
  logic [1:0]            run_level;
  logic [7:0]            quantum;
  logic [15:0]           phase;

  logic [TW-1:0]         cur_id;
  logic [1:0]            lv_cur;
  logic                  run_is_id;
  logic [TIME_WIDTH-1:0] len_sat;
  logic [1:0]            selq;
  logic                  any_queued;
  logic [1:0]            hl;
  logic [TIME_WIDTH-1:0] rem_new;
  logic [7:0]            q_new;
  logic [1:0]            next_lv;
  logic [CW-1:0]         sw_pm1;
  logic [32:0]           wait_x;
  logic [32:0]           tat;
  logic                  wen;
  logic                  push_inc;
  logic [1:0]            wq;
  logic [TW-1:0]         wp;
  logic [TW-1:0]         wd;
  logic                  cnt_ok;

  function automatic logic [7:0] slice_for(input logic [1:0] lv, input mlfq_pkg::cfg_t c);
    case (lv)
      2'd1:    slice_for = c.q1;
      2'd2:    slice_for = c.q2;
      default: slice_for = c.q3;
    endcase
  endfunction

  function automatic logic [TIME_WIDTH-1:0] sat_inc(input logic [TIME_WIDTH-1:0] v);
    sat_inc = (v == TMAX) ? v : v + TIME_WIDTH'(1);
  endfunction

  assign cur_id     = TW'(cur.task_id);
  assign lv_cur     = task_level[tidx];
  assign run_is_id  = run_valid && (run_id == tidx);
  assign len_sat    = (33'(cur.burst_length) > 33'(TMAX)) ? TMAX
                                                          : TIME_WIDTH'(cur.burst_length);
  assign any_queued = (cnt[0] != '0) || (cnt[1] != '0) || (cnt[2] != '0);
  assign selq       = (cnt[0] != '0) ? 2'd0 : ((cnt[1] != '0) ? 2'd1 : 2'd2);
  assign hl         = selq + 2'd1;
  assign rem_new    = (rem[tidx] != '0) ? rem[tidx] - TIME_WIDTH'(1) : '0;
  assign q_new      = (quantum != 8'd0) ? quantum - 8'd1 : 8'd0;
  assign next_lv    = (run_level == 2'd3) ? 2'd3 : run_level + 2'd1;
  assign sw_pm1     = sw_p - CW'(1);
  assign wait_x     = 33'(wait_cnt[tidx]);
  assign tat        = 33'(exec_cnt[tidx]) + wait_x;
  assign cnt_ok     = (cnt[0] <= CW'(TASK_COUNT)) && (cnt[1] <= CW'(TASK_COUNT)) &&
                      (cnt[2] <= CW'(TASK_COUNT));

  always_comb begin
    res_load             = '0;
    res_load.result_task = (item.operation == mlfq_pkg::OP_TICK) ? 4'd0 : item.task_id;
  end

  always_comb begin
    status.operation  = cur.operation;
    status.id_ok      = 7'(cur.task_id) < 7'(TASK_COUNT);
    status.busy       = (lv_cur != 2'd0) || run_is_id;
    status.len_zero   = (cur.burst_length == 16'd0);
    status.run_is_id  = run_is_id;
    status.level_nz   = (lv_cur != 2'd0);
    status.boost_due  = (phase >= cfg.interval);
    status.sched_take = any_queued && (!run_valid || (hl < run_level));
    status.run_valid  = run_valid;
    status.sw_done    = (sw_p >= cnt[sw_q]);
    status.wait_last  = (tidx == TW'(TASK_COUNT - 1));
    status.out_free   = !result_valid || result_ready;
  end

  // single write port of the queue store
  always_comb begin
    wen = 1'b0;
    wq  = 2'd0;
    wp  = '0;
    wd  = '0;
    case (cmd.op)
      mlfq_pkg::CMD_BURST: begin
        wen = cnt[0] < CW'(TASK_COUNT);
        wq  = 2'd0;
        wp  = cnt[0][TW-1:0];
        wd  = tidx;
      end
      mlfq_pkg::CMD_SCHED_PUSH: begin
        wq  = run_level - 2'd1;
        wen = run_valid && (cnt[wq] < CW'(TASK_COUNT));
        wp  = cnt[wq][TW-1:0];
        wd  = run_id;
      end
      mlfq_pkg::CMD_RUN: begin
        wq  = next_lv - 2'd1;
        wen = (rem_new != '0) && (q_new == 8'd0) && (cnt[wq] < CW'(TASK_COUNT));
        wp  = cnt[wq][TW-1:0];
        wd  = run_id;
      end
      mlfq_pkg::CMD_SW_WR: begin
        if (sw_move) begin
          wen = cnt[0] < CW'(TASK_COUNT);
          wq  = 2'd0;
          wp  = cnt[0][TW-1:0];
        end else begin
          wen = sw_found && (sw_p != '0);
          wq  = sw_q;
          wp  = sw_pm1[TW-1:0];
        end
        wd = rdata;
      end
      default: ;
    endcase
  end

  assign push_inc = wen && !((cmd.op == mlfq_pkg::CMD_SW_WR) && !sw_move);

  always_ff @(posedge clk) begin
    if (wen) qmem[wq][wp] <= wd;
    if (cmd.op == mlfq_pkg::CMD_SW_RD) rdata <= qmem[sw_q][sw_p[TW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < TASK_COUNT; i++) begin
        task_level[i] <= 2'd0;
        req[i]        <= '0;
        rem[i]        <= '0;
        exec_cnt[i]   <= '0;
        wait_cnt[i]   <= '0;
      end
      for (int i = 0; i < 3; i++) cnt[i] <= '0;
      run_valid    <= 1'b0;
      run_id       <= '0;
      run_level    <= 2'd0;
      quantum      <= 8'd0;
      phase        <= 16'd1;
      result_valid <= 1'b0;
      sw_p         <= '0;
      sw_q         <= 2'd0;
      sw_found     <= 1'b0;
      sw_move      <= 1'b0;
      tidx         <= '0;
    end else begin
      if (result_valid && result_ready && (cmd.op != mlfq_pkg::CMD_EMIT))
        result_valid <= 1'b0;
      if (push_inc) cnt[wq] <= cnt[wq] + CW'(1);
      case (cmd.op)
        mlfq_pkg::CMD_LOAD: begin
          cur  <= item;
          tidx <= TW'(item.task_id);
          res  <= res_load;
        end
        mlfq_pkg::CMD_ERROR: res.kind <= mlfq_pkg::KIND_ERROR;
        mlfq_pkg::CMD_NEW: begin
          task_level[tidx] <= 2'd0;
          req[tidx]        <= '0;
          rem[tidx]        <= '0;
          exec_cnt[tidx]   <= '0;
          wait_cnt[tidx]   <= '0;
          res.kind         <= mlfq_pkg::KIND_NEW_OK;
        end
        mlfq_pkg::CMD_BURST: begin
          req[tidx]        <= len_sat;
          rem[tidx]        <= len_sat;
          task_level[tidx] <= 2'd1;
          res.kind         <= mlfq_pkg::KIND_BURST;
          res.requested    <= 16'(len_sat);
          res.level        <= 2'd1;
        end
        mlfq_pkg::CMD_EXIT_SEARCH: begin
          sw_q     <= lv_cur - 2'd1;
          sw_p     <= '0;
          sw_found <= 1'b0;
          sw_move  <= 1'b0;
        end
        mlfq_pkg::CMD_EXIT_REPORT: begin
          task_level[tidx] <= 2'd0;
          if (lv_cur != 2'd0) rem[tidx] <= '0;
          res.kind       <= mlfq_pkg::KIND_EXIT;
          res.wait_total <= (wait_x > 33'h0FFFF) ? 16'hFFFF : wait_x[15:0];
          res.turnaround <= (tat > 33'h1FFFF) ? 17'h1FFFF : tat[16:0];
        end
        mlfq_pkg::CMD_PHASE: begin
          if (phase >= cfg.interval) begin
            phase       <= 16'd1;
            res.boosted <= 1'b1;
            if (run_valid) begin
              task_level[run_id] <= 2'd1;
              run_level          <= 2'd1;
              if (quantum > cfg.cap) quantum <= cfg.cap;
            end
            // level three drains first
            sw_q    <= 2'd2;
            sw_p    <= '0;
            sw_move <= 1'b1;
          end else begin
            phase <= phase + 16'd1;
          end
        end
        mlfq_pkg::CMD_MOVE_L2: begin
          sw_q    <= 2'd1;
          sw_p    <= '0;
          sw_move <= 1'b1;
        end
        mlfq_pkg::CMD_SCHED_PUSH: begin
          sw_q     <= selq;
          sw_p     <= '0;
          sw_found <= 1'b1;
          sw_move  <= 1'b0;
          sched_hl <= hl;
        end
        mlfq_pkg::CMD_SCHED_SET: begin
          run_id    <= sw_head;
          run_valid <= 1'b1;
          run_level <= sched_hl;
          quantum   <= slice_for(sched_hl, cfg);
        end
        mlfq_pkg::CMD_WAIT_INIT: tidx <= '0;
        mlfq_pkg::CMD_WAIT_STEP: begin
          if ((lv_cur != 2'd0) && !run_is_id) wait_cnt[tidx] <= sat_inc(wait_cnt[tidx]);
          if (tidx != TW'(TASK_COUNT - 1)) tidx <= tidx + TW'(1);
        end
        mlfq_pkg::CMD_RUN_SEL: tidx <= run_id;
        mlfq_pkg::CMD_IDLE: res.kind <= mlfq_pkg::KIND_IDLE;
        mlfq_pkg::CMD_RUN: begin
          exec_cnt[tidx]  <= sat_inc(exec_cnt[tidx]);
          rem[tidx]       <= rem_new;
          quantum         <= q_new;
          res.kind        <= mlfq_pkg::KIND_RAN;
          res.result_task <= 4'(run_id);
          res.requested   <= 16'(req[tidx]);
          res.used        <= 16'(req[tidx] - rem_new);
          res.level       <= run_level;
          if (rem_new == '0) begin
            task_level[tidx] <= 2'd0;
            run_valid        <= 1'b0;
          end else if (q_new == 8'd0) begin
            task_level[tidx] <= next_lv;
            run_valid        <= 1'b0;
          end
        end
        mlfq_pkg::CMD_SW_WR: begin
          if (sw_move) begin
            task_level[rdata] <= 2'd1;
          end else begin
            if (sw_p == '0) sw_head <= rdata;
            if (!sw_found && (rdata == cur_id)) sw_found <= 1'b1;
          end
          sw_p <= sw_p + CW'(1);
        end
        mlfq_pkg::CMD_SW_END: begin
          if (sw_move) cnt[sw_q] <= '0;
          else if (sw_found) cnt[sw_q] <= cnt[sw_q] - CW'(1);
        end
        mlfq_pkg::CMD_EMIT: begin
          result       <= res;
          result_valid <= 1'b1;
        end
        default: ;
      endcase
    end
  end

  // a boost fills level one before the drained queue is cleared, so each count is bounded
  `MLFQ_ASSERT(a_queue_bound, cnt_ok)
  `MLFQ_ASSERT_IMP(a_run_level, run_valid, task_level[run_id] == run_level)
  `MLFQ_ASSERT_IMP(a_sweep_range, cmd.op == mlfq_pkg::CMD_SW_RD, sw_p < cnt[sw_q])

endmodule

>>> hw/rtl/mlfq_three_level_scheduler.sv
// new task, burst, error and exit of an unqueued task: decode, then the result is emitted
// exit of a queued task: a sweep of its queue removes the entry before the exit is reported
// tick: phase step, a sweep moving levels three and two to level one on a boost, a dispatch
// sweep when none runs or a higher level waits, a wait scan of all tasks, then a run step if any
// one item at a time; the next item can be taken in the same cycle its result is raised
// synchronous reset: all queues empty, no task running, boost phase one, registers at defaults
module mlfq_three_level_scheduler #(
  parameter int TASK_COUNT = 16,
  parameter int TIME_WIDTH = 16
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                item_valid,
  output logic                item_ready,
  input  mlfq_pkg::item_t     item,
  output logic                result_valid,
  input  logic                result_ready,
  output mlfq_pkg::result_t   result,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [4:0]          paddr,
  input  logic [31:0]         pwdata,
  output logic [31:0]         prdata,
  output logic                pready
);

  mlfq_pkg::cfg_t    cfg;
  mlfq_pkg::cmd_t    cmd;
  mlfq_pkg::status_t status;

  mlfq_regs u_regs (
    .clk, .rst, .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready, .cfg
  );

  mlfq_ctrl u_ctrl (
    .clk, .rst, .item_valid, .item_ready, .status, .cmd
  );

  mlfq_dp #(
    .TASK_COUNT(TASK_COUNT),
    .TIME_WIDTH(TIME_WIDTH)
  ) u_dp (
    .clk, .rst, .cmd, .status, .cfg, .item, .result, .result_valid, .result_ready
  );

endmodule
